@@ rtl/ced_pkg.sv @@
// shared types, constants and helpers for the escape sequence decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package ced_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_VT  = 8'd11;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_ESC = 8'd27;

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_ESC  = 3'd1,
        M_ZERO = 3'd2,
        M_OCT1 = 3'd3,
        M_OCT2 = 3'd4,
        M_HEX0 = 3'd5,
        M_HEX1 = 3'd6
    } mode_t;

    typedef struct packed {
        logic [7:0] value;
        logic       overflow;
        logic       final_res;
    } res_t;

    // one queue entry: the results caused by one input word
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } pkt_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] h;
        h = 5'd16;
        if (c >= CH_ZERO && c <= CH_NINE)
            h = 5'(c - CH_ZERO);
        else if (c >= CH_UP_A && c <= CH_UP_F)
            h = 5'(c - CH_UP_A + 8'd10);
        else if (c >= CH_LO_A && c <= CH_LO_F)
            h = 5'(c - CH_LO_A + 8'd10);
        return h;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ced_front.sv @@
// front end: escape state machine, turns one character into up to two results
// uses ced_pkg; feeds ced_queue
`default_nettype none

module ced_front
    import ced_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_text,
    output      logic       push,
    output      pkt_t       pkt
);

    mode_t       mode_reg, mode_next;
    logic [8:0]  acc_reg, acc_next;
    logic [7:0]  val [2];
    logic        ov [2];
    logic [1:0]  cnt;
    logic [7:0]  own_c;
    logic        own_en;
    logic [4:0]  h;
    logic [8:0]  oct_v;
    logic [2:0]  dig;

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        val[0]    = 8'd0;
        val[1]    = 8'd0;
        ov[0]     = 1'b0;
        ov[1]     = 1'b0;
        cnt       = 2'd0;
        own_en    = 1'b0;
        own_c     = ch;
        h         = hex_val(ch);
        dig       = ch[2:0];
        oct_v     = {acc_reg[5:0], dig};

        case (mode_reg)
            M_ESC:
            begin
                acc_next  = 9'd0;
                mode_next = M_IDLE;
                cnt       = 2'd1;
                case (ch)
                    CH_LO_A: val[0] = CODE_BEL;
                    CH_LO_B: val[0] = CODE_BS;
                    CH_LO_E: val[0] = CODE_ESC;
                    CH_LO_F: val[0] = CODE_FF;
                    CH_LO_N: val[0] = CODE_LF;
                    CH_LO_R: val[0] = CODE_CR;
                    CH_LO_T: val[0] = CODE_HT;
                    CH_LO_V: val[0] = CODE_VT;
                    CH_ZERO:
                    begin
                        mode_next = M_ZERO;
                        cnt       = 2'd0;
                    end
                    CH_LO_X:
                    begin
                        mode_next = M_HEX0;
                        cnt       = 2'd0;
                    end
                    default:
                    begin
                        if (ch >= CH_ONE && ch <= CH_SEVEN)
                        begin
                            acc_next  = {6'd0, dig};
                            mode_next = M_OCT1;
                            cnt       = 2'd0;
                        end
                        else
                            val[0] = ch;
                    end
                endcase
            end
            M_ZERO:
            begin
                if (ch >= CH_ONE && ch <= CH_SEVEN)
                begin
                    acc_next  = {6'd0, dig};
                    mode_next = M_OCT2;
                end
                else
                begin
                    cnt    = 2'd1;
                    own_en = 1'b1;
                end
            end
            M_OCT1:
            begin
                if (is_oct(ch))
                begin
                    acc_next  = oct_v;
                    mode_next = M_OCT2;
                end
                else
                begin
                    val[0] = acc_reg[7:0];
                    cnt    = 2'd1;
                    own_en = 1'b1;
                end
            end
            M_OCT2:
            begin
                cnt = 2'd1;
                if (is_oct(ch))
                begin
                    val[0]    = oct_v[7:0];
                    ov[0]     = oct_v[8];
                    acc_next  = 9'd0;
                    mode_next = M_IDLE;
                end
                else
                begin
                    val[0] = acc_reg[7:0];
                    own_en = 1'b1;
                end
            end
            M_HEX0:
            begin
                if (!h[4])
                begin
                    acc_next  = {5'd0, h[3:0]};
                    mode_next = M_HEX1;
                end
                else
                begin
                    val[0] = CH_LO_X;
                    cnt    = 2'd1;
                    own_en = 1'b1;
                end
            end
            M_HEX1:
            begin
                cnt = 2'd1;
                if (!h[4])
                begin
                    val[0]    = {acc_reg[3:0], h[3:0]};
                    acc_next  = 9'd0;
                    mode_next = M_IDLE;
                end
                else
                begin
                    val[0] = acc_reg[7:0];
                    own_en = 1'b1;
                end
            end
            default:
            begin
                own_en = 1'b1;
            end
        endcase

        // character that ends a run is handled as if idle
        if (own_en)
        begin
            acc_next = 9'd0;
            if (own_c == CH_BSLASH)
                mode_next = M_ESC;
            else
            begin
                mode_next    = M_IDLE;
                val[cnt[0]]  = own_c;
                ov[cnt[0]]   = 1'b0;
                cnt          = cnt + 2'd1;
            end
        end

        // flush whatever escape is still pending
        if (end_of_text)
        begin
            case (mode_next)
                M_ESC:
                begin
                    val[cnt[0]] = CH_BSLASH;
                    cnt         = cnt + 2'd1;
                end
                M_ZERO:
                begin
                    val[cnt[0]] = 8'd0;
                    cnt         = cnt + 2'd1;
                end
                M_OCT1, M_OCT2, M_HEX1:
                begin
                    val[cnt[0]] = acc_next[7:0];
                    cnt         = cnt + 2'd1;
                end
                M_HEX0:
                begin
                    val[cnt[0]] = CH_LO_X;
                    cnt         = cnt + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next = M_IDLE;
            acc_next  = 9'd0;
        end
    end

    always_comb
    begin
        push              = take && (cnt != 2'd0);
        pkt.two           = (cnt == 2'd2);
        pkt.r0.value      = val[0];
        pkt.r0.overflow   = ov[0];
        pkt.r0.final_res  = end_of_text && (cnt == 2'd1);
        pkt.r1.value      = val[1];
        pkt.r1.overflow   = ov[1];
        pkt.r1.final_res  = end_of_text && (cnt == 2'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            acc_reg  <= 9'd0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ced_queue.sv @@
// short register queue of result packets between front and back end
// uses ced_pkg for the packet type
`default_nettype none

module ced_queue
    import ced_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire pkt_t din,
    input  wire logic pop,
    output      pkt_t dout,
    output      logic empty,
    output      logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pkt_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        empty    = (cnt_reg == '0);
        full     = (cnt_reg == CNT_W'(DEPTH));
        dout     = mem_reg[rd_reg];
        wr_next  = push ? ptr_inc(wr_reg) : wr_reg;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ced_back.sv @@
// back end: hands the one or two results of each packet out as words
// uses ced_pkg; reads the head of ced_queue
`default_nettype none

module ced_back
    import ced_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire pkt_t       head,
    input  wire logic       empty,
    output      logic       pop,
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,
    output      logic       m_tuser,
    output      logic       m_tlast
);

    logic idx_reg, idx_next;
    res_t cur;

    always_comb
    begin
        m_tvalid = !empty;
        cur      = idx_reg ? head.r1 : head.r0;
        m_tdata  = cur.value;
        m_tuser  = cur.overflow;
        m_tlast  = cur.final_res;
        // second word of a pair, or the only word
        pop      = m_tvalid && m_tready && (idx_reg || !head.two);
        idx_next = idx_reg;
        if (m_tvalid && m_tready)
            idx_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 1'b0;
        else
            idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

@@ rtl/c_escape_sequence_decoder.sv @@
// top level of the escape sequence decoder: front end, packet queue, back end
// depends on ced_pkg, ced_front, ced_queue and ced_back

// Decodes the body of a C string literal, one character per word. The input
// side takes one word per cycle whenever the packet queue has room; each word
// yields zero, one or two output words, and the output side sends one word per
// cycle while m_tready is high, so a word that yields two results (a terminator
// after an escape run, or a flush at end of text) is sent as two output words.
// The queue of QUEUE_DEPTH packets lets the front end run on while the output
// side is stalled; the results of an accepted character are registered in the
// queue before they reach the output. s_tlast marks the final character: any
// pending escape is flushed and m_tlast marks the last result it causes.
// m_tuser flags an octal value above 255 that was truncated to eight bits.
`default_nettype none

module c_escape_sequence_decoder
    import ced_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] ch
    input  wire logic       s_tlast,   // end_of_text
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // [7:0] value
    output      logic       m_tuser,   // [0] overflow
    output      logic       m_tlast    // final_res
);

    logic take;
    logic push;
    logic pop;
    logic empty;
    logic full;
    pkt_t pkt_in;
    pkt_t pkt_head;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    ced_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .ch          (s_tdata),
        .end_of_text (s_tlast),
        .push        (push),
        .pkt         (pkt_in)
    );

    ced_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (pkt_in),
        .pop   (pop),
        .dout  (pkt_head),
        .empty (empty),
        .full  (full)
    );

    ced_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (pkt_head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
